// ===== rtl/pfvf_pkg.sv =====
`timescale 1ns / 1ps
package pfvf_pkg;

	localparam int ROM_ROWS      = 9;
	localparam int ROM_MAX_BYTES = 6;
	localparam int ROW_W         = 4;
	localparam int IDX_W         = 3;
	localparam int TAG_W         = 16;
	localparam int LEN_W         = 15;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_FILL = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// One classified entry, handed from the parser to the emitter.
	typedef struct packed {
		logic             err;
		logic             matched;
		logic [ROW_W-1:0] row;
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] len;
		logic             last;
	} job_t;

	function automatic logic [TAG_W-1:0] rom_tag(input logic [ROW_W-1:0] row);
		logic [TAG_W-1:0] t;
		case (row)
			4'd0: t = 16'h9F59;
			4'd1: t = 16'h9F58;
			4'd2: t = 16'h9F40;
			4'd3: t = 16'h9F02;
			4'd4: t = 16'h9F1A;
			4'd5: t = 16'h5F2A;
			4'd6: t = 16'h009A;
			4'd7: t = 16'h9F37;
			4'd8: t = 16'h9F66;
			default: t = 16'h0000;
		endcase
		return t;
	endfunction

	function automatic logic [IDX_W-1:0] rom_size(input logic [ROW_W-1:0] row);
		logic [IDX_W-1:0] s;
		case (row)
			4'd0: s = 3'd3;
			4'd1: s = 3'd1;
			4'd2: s = 3'd4;
			4'd3: s = 3'd6;
			4'd4: s = 3'd2;
			4'd5: s = 3'd2;
			4'd6: s = 3'd3;
			4'd7: s = 3'd4;
			4'd8: s = 3'd4;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

	// Row bytes packed first byte in the top position.
	function automatic logic [7:0] rom_byte(input logic [ROW_W-1:0] row,
			input logic [IDX_W-1:0] idx);
		logic [8*ROM_MAX_BYTES-1:0] r;
		logic [7:0] b;
		case (row)
			4'd0: r = 48'hC8_80_00_00_00_00;
			4'd1: r = 48'h01_00_00_00_00_00;
			4'd2: r = 48'h79_00_40_80_00_00;
			4'd3: r = 48'h00_00_00_10_00_00;
			4'd4: r = 48'h01_24_00_00_00_00;
			4'd5: r = 48'h01_24_00_00_00_00;
			4'd6: r = 48'h19_01_01_00_00_00;
			4'd7: r = 48'h82_3D_DE_7A_00_00;
			4'd8: r = 48'hF0_00_00_00_00_00;
			default: r = '0;
		endcase
		case (idx)
			3'd0: b = r[47:40];
			3'd1: b = r[39:32];
			3'd2: b = r[31:24];
			3'd3: b = r[23:16];
			3'd4: b = r[15:8];
			3'd5: b = r[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/pfvf_if.sv =====
`timescale 1ns / 1ps
interface pfvf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] list_byte;
	logic       final_byte;

	modport source(output valid, output list_byte, output final_byte, input ready);
	modport sink(input valid, input list_byte, input final_byte, output ready);
endinterface

interface pfvf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [14:0] fill_count;
	logic [15:0] entry_tag;
	logic        entry_done;
	logic        list_done;

	modport source(output valid, output kind, output data_byte, output fill_count,
		output entry_tag, output entry_done, output list_done, input ready);
	modport sink(input valid, input kind, input data_byte, input fill_count,
		input entry_tag, input entry_done, input list_done, output ready);
endinterface

// ===== rtl/pfvf_front.sv =====
`timescale 1ns / 1ps
module pfvf_front #(
	parameter int FIXED_ENTRIES = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	pfvf_in_if.sink           in_ch,
	input  logic              q_full,
	output logic              q_push,
	output pfvf_pkg::job_t    q_job
);
	import pfvf_pkg::*;

	localparam int SEARCH_ROWS = (FIXED_ENTRIES < ROM_ROWS) ? FIXED_ENTRIES : ROM_ROWS;

	localparam logic [1:0] PH_TAG0 = 2'd0;
	localparam logic [1:0] PH_TAG1 = 2'd1;
	localparam logic [1:0] PH_LEN0 = 2'd2;
	localparam logic [1:0] PH_LEN1 = 2'd3;

	logic [1:0]       phase_q, phase_d;
	logic [TAG_W-1:0] tag_q, tag_d;
	logic [6:0]       len_hi_q, len_hi_d;
	logic [LEN_W-1:0] len;
	logic             done;
	logic             accept;
	logic             matched;
	logic [ROW_W-1:0] row;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		phase_d  = phase_q;
		tag_d    = tag_q;
		len_hi_d = len_hi_q;
		len      = '0;
		done     = 1'b0;
		case (phase_q)
			PH_TAG0: begin
				tag_d   = {8'h00, in_ch.list_byte};
				phase_d = (in_ch.list_byte[4:0] == 5'h1F) ? PH_TAG1 : PH_LEN0;
			end
			PH_TAG1: begin
				tag_d   = {tag_q[7:0], in_ch.list_byte};
				phase_d = PH_LEN0;
			end
			PH_LEN0: begin
				if (in_ch.list_byte[7]) begin
					len_hi_d = in_ch.list_byte[6:0];
					phase_d  = PH_LEN1;
				end else begin
					len  = {7'd0, in_ch.list_byte};
					done = 1'b1;
				end
			end
			PH_LEN1: begin
				len  = {len_hi_q, in_ch.list_byte};
				done = 1'b1;
			end
			default: phase_d = PH_TAG0;
		endcase
	end

	// Priority search: lowest matching row wins.
	always_comb begin
		matched = 1'b0;
		row     = '0;
		for (int i = SEARCH_ROWS - 1; i >= 0; i--) begin
			if (rom_tag(ROW_W'(i)) == tag_q && LEN_W'(rom_size(ROW_W'(i))) == len) begin
				matched = 1'b1;
				row     = ROW_W'(i);
			end
		end
	end

	assign q_push        = accept && (done || in_ch.final_byte);
	assign q_job.err     = !done;
	assign q_job.matched = done && matched;
	assign q_job.row     = row;
	assign q_job.tag     = tag_d;
	assign q_job.len     = len;
	assign q_job.last    = in_ch.final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG0;
			tag_q    <= '0;
			len_hi_q <= '0;
		end else if (accept) begin
			if (done || in_ch.final_byte) begin
				// Entry closed or list cut short: start over.
				phase_q  <= PH_TAG0;
				tag_q    <= '0;
				len_hi_q <= '0;
			end else begin
				phase_q  <= phase_d;
				tag_q    <= tag_d;
				len_hi_q <= len_hi_d;
			end
		end
	end

endmodule

// ===== rtl/pfvf_queue.sv =====
`timescale 1ns / 1ps
module pfvf_queue #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/pfvf_back.sv =====
`timescale 1ns / 1ps
module pfvf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  pfvf_pkg::job_t    q_job,
	output logic              q_pop,
	pfvf_out_if.source        out_ch
);
	import pfvf_pkg::*;

	logic             busy_q;
	job_t             job_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [1:0]       kind_q;
	logic [7:0]       data_q;
	logic [LEN_W-1:0] fill_q;
	logic [TAG_W-1:0] tag_q;
	logic             edone_q;
	logic             ldone_q;

	logic             load_out;
	logic             emit;
	logic             last_res;
	logic             job_done;
	logic [1:0]       kind;
	logic [7:0]       data;
	logic [LEN_W-1:0] fill;

	assign load_out = !out_valid_q || out_ch.ready;
	assign emit     = busy_q && load_out;

	always_comb begin
		if (job_q.err) begin
			kind     = KIND_ERR;
			data     = 8'h00;
			fill     = '0;
			last_res = 1'b1;
		end else if (job_q.matched) begin
			kind     = KIND_DATA;
			data     = rom_byte(job_q.row, idx_q);
			fill     = '0;
			last_res = (idx_q == rom_size(job_q.row) - 3'd1);
		end else begin
			kind     = KIND_FILL;
			data     = 8'h00;
			fill     = job_q.len;
			last_res = 1'b1;
		end
	end

	assign job_done = emit && last_res;
	// Take the next job in the same cycle the current one finishes.
	assign q_pop    = q_valid && (!busy_q || job_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (job_done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (emit) begin
			kind_q  <= kind;
			data_q  <= data;
			fill_q  <= fill;
			tag_q   <= job_q.tag;
			edone_q <= last_res;
			ldone_q <= last_res && job_q.last;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.kind       = kind_q;
	assign out_ch.data_byte  = data_q;
	assign out_ch.fill_count = fill_q;
	assign out_ch.entry_tag  = tag_q;
	assign out_ch.entry_done = edone_q;
	assign out_ch.list_done  = ldone_q;

	a_err_closes_list: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_ERR |-> edone_q && ldone_q)
		else $error("error result does not close entry and list");

	a_list_implies_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ldone_q |-> edone_q)
		else $error("list end without entry end");

	a_idx_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !job_q.err && job_q.matched |-> idx_q < rom_size(job_q.row))
		else $error("byte index ran past the fixed row");

endmodule

// ===== rtl/pdol_fixed_value_filler.sv =====
`timescale 1ns / 1ps
// PDOL fixed-value filler. Bytes of a data object list enter on in_ch, one
// transaction per byte, with final_byte marking the last. The front parser
// takes one byte per cycle while the job queue is not full, assembles each
// tag/length pair, and looks it up in a fixed table of FIXED_ENTRIES rows
// (nine at most); a match yields the row's bytes as kind 0 results, one per
// cycle while the output is taken, otherwise a single kind 1 zero-fill run
// carrying the length. A list that ends inside an entry yields one kind 2
// result and the parser starts over. Classified entries wait in a queue of
// QUEUE_DEPTH jobs; the emitter drains it at one result per cycle while the
// output is taken, with no gap between jobs, behind an output register, so
// input and output stall independently. A complete entry takes at least
// two input bytes and yields one to six results, so input runs at one byte
// per cycle unless the output stalls or short entries with long fixed rows
// fill the queue, when it runs at the emitter's pace of one result per cycle.
module pdol_fixed_value_filler #(
	parameter int FIXED_ENTRIES = 9,
	parameter int QUEUE_DEPTH   = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	pfvf_in_if.sink      in_ch,
	pfvf_out_if.source   out_ch
);
	import pfvf_pkg::*;

	job_t front_job;
	job_t back_job;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_valid;

	// Parse and classify; push one job per finished or truncated entry.
	pfvf_front #(
		.FIXED_ENTRIES(FIXED_ENTRIES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (front_job)
	);

	// Decouple parser from emitter.
	pfvf_queue #(
		.WIDTH($bits(job_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (front_job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (back_job),
		.not_empty (q_valid)
	);

	// Expand each job into its result transactions.
	pfvf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_job   (back_job),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

// ===== tb/tb_pdol_fixed_value_filler.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the PDOL fixed-value filler. A directed table opens
// the run, then random data object lists follow. Every accepted list byte is
// run through a local parser model, and every result transaction leaving the
// block is checked against the oldest pending expectation.
module tb_pdol_fixed_value_filler;
	import pfvf_pkg::*;

	localparam int FIXED_ENTRIES = 9;
	localparam int RANDOM_ITEMS  = 305;
	localparam int HOLD_CYCLES   = 400;    // long output stall to fill the job queue
	localparam int DRAIN_CYCLES  = 20;     // quiet window after the last result
	localparam int CYCLE_LIMIT   = 200000;

	// Parser position inside one tag/length pair.
	typedef enum logic [1:0] {
		PH_TAG0,
		PH_TAG1,
		PH_LEN0,
		PH_LEN1
	} list_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [14:0] fill_count;
		logic [15:0] entry_tag;
		logic        entry_done;
		logic        list_done;
	} fill_result_t;

	// One list byte; typed rows carry a hand-written expectation.
	typedef struct packed {
		logic [7:0]   list_byte;
		logic         final_byte;
		logic         typed;
		fill_result_t exp;
	} list_item_t;

	localparam fill_result_t NO_CHECK = '0;

	logic clk;
	logic arst_n;

	pfvf_in_if  list_ch();
	pfvf_out_if result_ch();

	pdol_fixed_value_filler u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (list_ch),
		.out_ch (result_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Directed opening. Rows with typed set hold an expectation that can be
	// read straight off the list; the rest go through the parser model.
	list_item_t directed_rows [25] = '{
		// list ends right after a one-byte tag: truncated
		'{8'h9A, 1'b1, 1'b1, '{KIND_ERR, 8'h00, 15'd0, 16'h009A, 1'b1, 1'b1}},
		// six-byte fixed row
		'{8'h9F, 1'b0, 1'b0, NO_CHECK},
		'{8'h02, 1'b0, 1'b0, NO_CHECK},
		'{8'h06, 1'b0, 1'b0, NO_CHECK},
		// one-byte fixed row closing the list
		'{8'h9F, 1'b0, 1'b0, NO_CHECK},
		'{8'h58, 1'b0, 1'b0, NO_CHECK},
		'{8'h01, 1'b1, 1'b0, NO_CHECK},
		// known tag, wrong length: zero fill
		'{8'h5F, 1'b0, 1'b0, NO_CHECK},
		'{8'h2A, 1'b0, 1'b0, NO_CHECK},
		'{8'h03, 1'b0, 1'b1, '{KIND_FILL, 8'h00, 15'd3, 16'h5F2A, 1'b1, 1'b0}},
		// zero length, no match
		'{8'h00, 1'b0, 1'b0, NO_CHECK},
		'{8'h00, 1'b0, 1'b1, '{KIND_FILL, 8'h00, 15'd0, 16'h0000, 1'b1, 1'b0}},
		// all-ones tag and longest length
		'{8'hFF, 1'b0, 1'b0, NO_CHECK},
		'{8'hFF, 1'b0, 1'b0, NO_CHECK},
		'{8'hFF, 1'b0, 1'b0, NO_CHECK},
		'{8'hFF, 1'b1, 1'b1, '{KIND_FILL, 8'h00, 15'h7FFF, 16'hFFFF, 1'b1, 1'b1}},
		// list ends after the first byte of a two-byte tag
		'{8'h1F, 1'b1, 1'b1, '{KIND_ERR, 8'h00, 15'd0, 16'h001F, 1'b1, 1'b1}},
		// list ends between the two length bytes
		'{8'h9F, 1'b0, 1'b0, NO_CHECK},
		'{8'h37, 1'b0, 1'b0, NO_CHECK},
		'{8'h80, 1'b1, 1'b1, '{KIND_ERR, 8'h00, 15'd0, 16'h9F37, 1'b1, 1'b1}},
		// long-form length that still hits a fixed row
		'{8'h9A, 1'b0, 1'b0, NO_CHECK},
		'{8'h80, 1'b0, 1'b0, NO_CHECK},
		'{8'h03, 1'b0, 1'b0, NO_CHECK},
		// list ends on the second tag byte
		'{8'h9F, 1'b0, 1'b0, NO_CHECK},
		'{8'h59, 1'b1, 1'b1, '{KIND_ERR, 8'h00, 15'd0, 16'h9F59, 1'b1, 1'b1}}
	};

	list_item_t   list_items [$];
	fill_result_t pending_results [$];
	fill_result_t step_results [$];

	// Parser model state, same reset as the block.
	list_phase_t list_phase = PH_TAG0;
	logic [15:0] tag_acc    = '0;
	logic [14:0] len_acc    = '0;

	int  accepted_items = 0;
	int  taken_results  = 0;
	int  fail_count     = 0;
	int  cycle_count    = 0;
	bit  squeeze        = 1'b0;

	// Fixed table: tag, data size, bytes with the first in the top position.
	function automatic void fixed_row(input int r, output logic [15:0] t, output int n,
			output logic [47:0] d);
		case (r)
			0: begin t = 16'h9F59; n = 3; d = 48'hC8_80_00_00_00_00; end
			1: begin t = 16'h9F58; n = 1; d = 48'h01_00_00_00_00_00; end
			2: begin t = 16'h9F40; n = 4; d = 48'h79_00_40_80_00_00; end
			3: begin t = 16'h9F02; n = 6; d = 48'h00_00_00_10_00_00; end
			4: begin t = 16'h9F1A; n = 2; d = 48'h01_24_00_00_00_00; end
			5: begin t = 16'h5F2A; n = 2; d = 48'h01_24_00_00_00_00; end
			6: begin t = 16'h009A; n = 3; d = 48'h19_01_01_00_00_00; end
			7: begin t = 16'h9F37; n = 4; d = 48'h82_3D_DE_7A_00_00; end
			default: begin t = 16'h9F66; n = 4; d = 48'hF0_00_00_00_00_00; end
		endcase
	endfunction

	function automatic fill_result_t make_result(input logic [1:0] kind,
			input logic [7:0] data, input logic [14:0] fill, input logic [15:0] tag,
			input logic edone, input logic ldone);
		fill_result_t r;
		r.kind       = kind;
		r.data_byte  = data;
		r.fill_count = fill;
		r.entry_tag  = tag;
		r.entry_done = edone;
		r.list_done  = ldone;
		return r;
	endfunction

	// Close a complete pair: emit the first matching row's bytes, or one
	// zero-fill run of the entry length, then return to the first tag byte.
	function automatic void close_entry(input logic last);
		logic [15:0] rtag;
		logic [47:0] rbytes;
		int          rlen;
		bit          hit;
		hit = 1'b0;
		for (int r = 0; r < FIXED_ENTRIES && r < ROM_ROWS && !hit; r++) begin
			fixed_row(r, rtag, rlen, rbytes);
			if (rtag == tag_acc && rlen == int'(len_acc)) begin
				hit = 1'b1;
				for (int j = 0; j < rlen; j++)
					step_results.insert(step_results.size(),
						make_result(KIND_DATA, rbytes[47-8*j -: 8], 15'd0, tag_acc,
						j == rlen - 1, (j == rlen - 1) && last));
			end
		end
		if (!hit)
			step_results.insert(step_results.size(),
				make_result(KIND_FILL, 8'h00, len_acc, tag_acc, 1'b1, last));
		list_phase = PH_TAG0;
		tag_acc    = '0;
		len_acc    = '0;
	endfunction

	// Advance the parser model by one list byte; results land in step_results.
	function automatic void pdol_predict(input logic [7:0] b, input logic last);
		step_results.delete();
		case (list_phase)
			PH_TAG0: begin
				tag_acc    = {8'h00, b};
				list_phase = (b[4:0] == 5'h1F) ? PH_TAG1 : PH_LEN0;
			end
			PH_TAG1: begin
				tag_acc    = {tag_acc[7:0], b};
				list_phase = PH_LEN0;
			end
			PH_LEN0: begin
				if (b[7]) begin
					len_acc    = {b[6:0], 8'h00};
					list_phase = PH_LEN1;
				end else begin
					len_acc = {7'd0, b};
					close_entry(last);
					return;
				end
			end
			default: begin
				len_acc = {len_acc[14:8], b};
				close_entry(last);
				return;
			end
		endcase
		// Entry still open: a final byte here truncates the list.
		if (last) begin
			step_results.insert(step_results.size(),
				make_result(KIND_ERR, 8'h00, 15'd0, tag_acc, 1'b1, 1'b1));
			list_phase = PH_TAG0;
			tag_acc    = '0;
			len_acc    = '0;
		end
	endfunction

	// Queue one random entry. With cut set, drop its tail and mark the last
	// kept byte final, so the list ends inside the entry.
	function automatic void add_entry(input bit cut);
		logic [7:0]  entry_bytes [$];
		logic [15:0] rtag;
		logic [47:0] rbytes;
		logic [7:0]  lead;
		logic [14:0] len;
		int          rlen;
		int          keep;
		bit          ends_list;
		if ($urandom_range(0, 1)) begin
			fixed_row($urandom_range(0, ROM_ROWS - 1), rtag, rlen, rbytes);
			// mostly the row's own size, now and then a near miss
			len = ($urandom_range(0, 4) == 0) ? 15'($urandom_range(0, 7)) : 15'(rlen);
			if (rtag[15:8] != 8'h00)
				entry_bytes.insert(entry_bytes.size(), rtag[15:8]);
			entry_bytes.insert(entry_bytes.size(), rtag[7:0]);
		end else begin
			lead = 8'($urandom_range(0, 255));
			entry_bytes.insert(entry_bytes.size(), lead);
			if (lead[4:0] == 5'h1F)
				entry_bytes.insert(entry_bytes.size(), 8'($urandom_range(0, 255)));
			case ($urandom_range(0, 9))
				0:       len = 15'($urandom_range(0, 32767));
				1, 2:    len = 15'($urandom_range(0, 255));
				default: len = 15'($urandom_range(0, 12));
			endcase
		end
		// short form where it fits, long form now and then regardless
		if (len < 15'd128 && $urandom_range(0, 3) != 0)
			entry_bytes.insert(entry_bytes.size(), len[7:0]);
		else begin
			entry_bytes.insert(entry_bytes.size(), {1'b1, len[14:8]});
			entry_bytes.insert(entry_bytes.size(), len[7:0]);
		end
		ends_list = ($urandom_range(0, 3) == 0);
		keep = cut ? int'($urandom_range(1, entry_bytes.size() - 1)) : entry_bytes.size();
		for (int k = 0; k < keep; k++)
			list_items.insert(list_items.size(), list_item_t'{entry_bytes[k],
				(k == keep - 1) && (cut || ends_list), 1'b0, NO_CHECK});
	endfunction

	function automatic void build_stimulus();
		logic [7:0] noise;
		logic       noise_last;
		int         pick;
		foreach (directed_rows[i])
			list_items.insert(list_items.size(), directed_rows[i]);
		// Mostly well-formed entries; some truncated lists and loose bytes.
		while (list_items.size() < $size(directed_rows) + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				add_entry(1'b0);
			else if (pick < 85)
				add_entry(1'b1);
			else begin
				noise      = 8'($urandom_range(0, 255));
				noise_last = ($urandom_range(0, 2) == 0);
				list_items.insert(list_items.size(),
					list_item_t'{noise, noise_last, 1'b0, NO_CHECK});
			end
		end
	endfunction

	function automatic void report_failure(input string what, input fill_result_t want,
			input fill_result_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t %s: want kind=%0d data=%02h fill=%0d tag=%04h ed=%0b ld=%0b",
				$realtime, what, want.kind, want.data_byte, want.fill_count,
				want.entry_tag, want.entry_done, want.list_done);
			$display("%0t %s: got  kind=%0d data=%02h fill=%0d tag=%04h ed=%0b ld=%0b",
				$realtime, what, got.kind, got.data_byte, got.fill_count,
				got.entry_tag, got.entry_done, got.list_done);
		end
	endfunction

	// Drive the list bytes in order. Draw a gap per byte; hold valid high
	// across back-to-back transactions, drop it only for a real gap.
	task automatic send_list();
		int gap;
		for (int i = 0; i < list_items.size(); i++) begin
			gap = (squeeze || (i / 40) % 3 == 0) ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				list_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			list_ch.valid      <= 1'b1;
			list_ch.list_byte  <= list_items[i].list_byte;
			list_ch.final_byte <= list_items[i].final_byte;
			do @(posedge clk); while (!list_ch.ready);
		end
		list_ch.valid <= 1'b0;
	endtask

	// Predict on every accepted list byte. Typed rows append their own
	// expectation; the model still advances so later rows stay in step.
	always @(posedge clk) begin
		if (arst_n && list_ch.valid && list_ch.ready) begin
			pdol_predict(list_ch.list_byte, list_ch.final_byte);
			if (list_items[accepted_items].typed)
				pending_results.insert(pending_results.size(),
					list_items[accepted_items].exp);
			else
				foreach (step_results[k])
					pending_results.insert(pending_results.size(), step_results[k]);
			accepted_items++;
		end
	end

	// Check every result transaction against the oldest expectation.
	always @(posedge clk) begin : result_check
		fill_result_t want;
		fill_result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = make_result(result_ch.kind, result_ch.data_byte, result_ch.fill_count,
				result_ch.entry_tag, result_ch.entry_done, result_ch.list_done);
			if (pending_results.size() == 0)
				report_failure("result with nothing pending", NO_CHECK, got);
			else begin
				want = pending_results.pop_front();
				if (want.kind !== got.kind || want.data_byte !== got.data_byte ||
						want.fill_count !== got.fill_count || want.entry_tag !== got.entry_tag ||
						want.entry_done !== got.entry_done || want.list_done !== got.list_done)
					report_failure("result mismatch", want, got);
			end
		end
	end

	// Result side: draw a stall per transaction, with stretches of none.
	// Once, hold ready low for a long count so the job queue backs up and
	// the block stalls its input while the sender keeps offering bytes.
	initial begin : result_taker
		int gap;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = ((taken_results / 50) % 3 == 1) ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			taken_results++;
			if (taken_results == 60) begin
				squeeze = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				squeeze = 1'b0;
			end
		end
	end

	// Bound the run in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_pdol_fixed_value_filler: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n             <= 1'b0;
		list_ch.valid      <= 1'b0;
		list_ch.list_byte  <= 8'h00;
		list_ch.final_byte <= 1'b0;
		build_stimulus();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_list();
		// let the monitor book the last transaction, then drain
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_pdol_fixed_value_filler: done, clean");
		else
			$display("tb_pdol_fixed_value_filler: done, errors");
		$finish;
	end

endmodule
